FILE: rtl/page_alloc_and_map_engine_macros.svh
// Assertion macros for the page allocate-and-map engine.
`ifndef PAGE_ALLOC_AND_MAP_ENGINE_MACROS_SVH
`define PAGE_ALLOC_AND_MAP_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define PAME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PAME_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define PAME_ASSERT(lbl, prop, msg)
`define PAME_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/pame_pkg.sv
// Shared types and constants of the page allocate-and-map engine.
package pame_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned VPN_W   = 20;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned OFS_W   = 12;
  localparam int unsigned FLAGS_W = 12;
  localparam int unsigned SIZE_W  = 19;
  localparam int unsigned CNT_CFG_W = 11;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BIT_W   = 5;

  localparam logic [VPN_W-1:0]     POOL_BASE_RST  = 20'd0;
  localparam logic [CNT_CFG_W-1:0] POOL_COUNT_RST = 11'd1024;
  localparam logic [VPN_W-1:0]     KOFS_RST       = 20'd786432;

  localparam logic [OFS_W-1:0] PTE_PRESENT  = 12'h001;
  localparam logic [OFS_W-1:0] PTE_WRITABLE = 12'h002;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MAP   = 2'd2,
    OP_UNMAP = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_POOL_COUNT  = 2'd1,
    CFG_KERNEL_OFS  = 2'd2
  } cfg_idx_e;

endpackage

FILE: rtl/pame_if.sv
// Request and response channel interfaces of the page allocate-and-map engine.
interface pame_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         opcode;
  logic [pame_pkg::ADDR_W-1:0]        virt_address;
  logic [pame_pkg::ADDR_W-1:0]        phys_address;
  logic [pame_pkg::FLAGS_W-1:0]       entry_flags;
  logic [pame_pkg::SIZE_W-1:0]        size_bytes;

  modport source (output valid, opcode, virt_address, phys_address, entry_flags,
                  size_bytes, input ready);
  modport sink (input valid, opcode, virt_address, phys_address, entry_flags,
                size_bytes, output ready);
endinterface

interface pame_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [pame_pkg::ADDR_W-1:0]        page_address;
  logic                               entry_write;
  logic [pame_pkg::IDX_W-1:0]         dir_index;
  logic [pame_pkg::IDX_W-1:0]         table_index;
  logic [pame_pkg::ADDR_W-1:0]        entry_value;
  logic                               dir_present;
  logic                               last;

  modport source (output valid, status, page_address, entry_write, dir_index,
                  table_index, entry_value, dir_present, last, input ready);
  modport sink (input valid, status, page_address, entry_write, dir_index,
                table_index, entry_value, dir_present, last, output ready);
endinterface

FILE: rtl/page_alloc_and_map_engine.sv
// Top level of the page allocate-and-map engine: page use map, allocator and PTE writer.
//
//   channel  dir  port                      beats per item
//   request  in   req_i (valid/ready)       1
//   response out  rsp_o (valid/ready)       1 .. MAX_RUN_PAGES, last marks the final one
//   config   in   cfg_we_i/cfg_index_i/...  write only, taken every cycle
//
// Alloc: one RAM read then a check per 32-page map word scanned, until a page is found
// or no page is free. Free: a pool check, then a read-modify-write of one map word; only
// the check when outside the pool. Map/unmap: one beat per entry, a single beat when empty.
// Each result beat waits while the output register is held by a stalled receiver.
// After reset the map RAM is cleared one word a cycle, with req_i.ready low. One item is
// worked at a time; a result beat waiting in the output register does not block the next
// request.
`include "page_alloc_and_map_engine_macros.svh"

module page_alloc_and_map_engine #(
  parameter int unsigned POOL_PAGES    = 1024,
  parameter int unsigned MAX_RUN_PAGES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [pame_pkg::VPN_W-1:0] cfg_wdata_i,
  pame_req_if.sink                   req_i,
  pame_rsp_if.source                 rsp_o
);

  localparam int unsigned WW     = pame_pkg::WORD_W;
  localparam int unsigned BW     = pame_pkg::BIT_W;
  localparam int unsigned VW     = pame_pkg::VPN_W;
  localparam int unsigned NWORDS = (POOL_PAGES + WW - 1) / WW;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned CNT_W  = $clog2(POOL_PAGES + 1);
  localparam int unsigned RUN_W  = $clog2(MAX_RUN_PAGES + 1);
  localparam int unsigned PIDX_W = AW + BW;

  typedef logic [WW-1:0] word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_ALLOC_VP,
    ST_ALLOC_OUT,
    ST_FREE_CHK,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_FREE_OUT,
    ST_RUN,
    ST_ZERO
  } state_e;

  function automatic logic [BW-1:0] onehot_enc(input word_t oh);
    logic [BW-1:0] r;
    r = '0;
    for (int j = 0; j < WW; j++) begin
      if (oh[j]) begin
        r = r | BW'(j);
      end
    end
    return r;
  endfunction

  // configuration
  logic [VW-1:0]                  pool_base_q;
  logic [pame_pkg::CNT_CFG_W-1:0] pool_count_q;
  logic [VW-1:0]                  kofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= pame_pkg::POOL_BASE_RST;
      pool_count_q <= pame_pkg::POOL_COUNT_RST;
      kofs_q       <= pame_pkg::KOFS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pame_pkg::CFG_POOL_BASE:  pool_base_q  <= cfg_wdata_i;
        pame_pkg::CFG_POOL_COUNT: pool_count_q <= cfg_wdata_i[pame_pkg::CNT_CFG_W-1:0];
        pame_pkg::CFG_KERNEL_OFS: kofs_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt_eff;
  assign cnt_eff = (VW'(pool_count_q) > VW'(POOL_PAGES)) ? CNT_W'(POOL_PAGES)
                                                         : CNT_W'(pool_count_q);

  // state
  state_e                state_q;
  logic [AW-1:0]         clr_q;
  logic [AW-1:0]         word_q;
  logic [CNT_W-1:0]      rem_q;
  logic [PIDX_W-1:0]     pidx_q;
  logic [VW-1:0]         idx_q;
  logic [VW-1:0]         vp_q;
  logic [VW-1:0]         pp_q;
  logic [pame_pkg::FLAGS_W-1:0] flags_q;
  logic                  is_map_q;
  logic [RUN_W-1:0]      run_left_q;
  pame_pkg::status_e     st_q;

  logic                  rsp_valid_q;
  logic [1:0]            rsp_status_q;
  logic [pame_pkg::ADDR_W-1:0] rsp_page_q;
  logic                  rsp_wr_q;
  logic [VW-1:0]         rsp_vp_q;
  logic [pame_pkg::ADDR_W-1:0] rsp_value_q;
  logic                  rsp_dirp_q;
  logic                  rsp_last_q;

  // memory
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  word_t         ram_wdata, ram_rdata;

  pame_ram #(
    .WIDTH (WW),
    .DEPTH (NWORDS)
  ) u_used_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // scan decode
  logic [VW-1:0]  rem_wide;
  word_t          scan_mask, avail, lowest;
  logic           hit;
  logic [BW-1:0]  hit_bit;
  logic [AW-1:0]  free_word;
  logic [BW-1:0]  free_bit;

  assign rem_wide  = VW'(rem_q);
  assign scan_mask = (rem_wide >= VW'(WW)) ? '1
                   : ((word_t'(1) << rem_wide[BW-1:0]) - word_t'(1));
  assign avail     = ~ram_rdata & scan_mask;
  assign hit       = |avail;
  assign lowest    = avail & (~avail + word_t'(1));
  assign hit_bit   = onehot_enc(lowest);
  assign free_word = idx_q[BW +: AW];
  assign free_bit  = idx_q[BW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = word_q;
    ram_raddr = word_q;
    ram_wdata = ram_rdata;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_SCAN_RD:  ram_re = (rem_q != '0);
      ST_SCAN_CHK: begin
        ram_we    = hit;
        ram_wdata = ram_rdata | lowest;
      end
      ST_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = free_word;
      end
      ST_FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = free_word;
        ram_wdata = ram_rdata & ~(word_t'(1) << free_bit);
      end
      default: ;
    endcase
  end

  // request decode
  logic [7:0]        run_raw;
  logic [RUN_W-1:0]  run_n;
  logic              req_acc;
  logic              out_free;
  logic              rsp_load;

  assign run_raw  = {1'b0, req_i.size_bytes[pame_pkg::SIZE_W-1:pame_pkg::OFS_W]}
                  + {7'd0, (req_i.opcode == pame_pkg::OP_MAP) &&
                           (req_i.size_bytes[pame_pkg::OFS_W-1:0] != '0)};
  assign run_n    = (run_raw > 8'(MAX_RUN_PAGES)) ? RUN_W'(MAX_RUN_PAGES)
                                                  : RUN_W'(run_raw);
  assign req_acc  = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign rsp_load = out_free && ((state_q == ST_ALLOC_OUT) || (state_q == ST_FREE_OUT) ||
                                 (state_q == ST_RUN) || (state_q == ST_ZERO));

  assign req_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      word_q       <= '0;
      rem_q        <= '0;
      pidx_q       <= '0;
      idx_q        <= '0;
      vp_q         <= '0;
      pp_q         <= '0;
      flags_q      <= '0;
      is_map_q     <= 1'b0;
      run_left_q   <= '0;
      st_q         <= pame_pkg::STATUS_OK;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= '0;
      rsp_page_q   <= '0;
      rsp_wr_q     <= 1'b0;
      rsp_vp_q     <= '0;
      rsp_value_q  <= '0;
      rsp_dirp_q   <= 1'b0;
      rsp_last_q   <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NWORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_acc) begin
            vp_q     <= req_i.virt_address[pame_pkg::ADDR_W-1:pame_pkg::OFS_W];
            pp_q     <= req_i.phys_address[pame_pkg::ADDR_W-1:pame_pkg::OFS_W];
            flags_q  <= req_i.entry_flags;
            idx_q    <= req_i.virt_address[pame_pkg::ADDR_W-1:pame_pkg::OFS_W] - pool_base_q;
            is_map_q <= (req_i.opcode == pame_pkg::OP_MAP);
            unique case (req_i.opcode)
              pame_pkg::OP_ALLOC: begin
                rem_q   <= cnt_eff;
                word_q  <= '0;
                state_q <= ST_SCAN_RD;
              end
              pame_pkg::OP_FREE: state_q <= ST_FREE_CHK;
              default: begin
                run_left_q <= run_n;
                st_q       <= pame_pkg::STATUS_OK;
                state_q    <= (run_n == '0) ? ST_ZERO : ST_RUN;
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          if (rem_q == '0) begin
            st_q    <= pame_pkg::STATUS_NO_FREE;
            state_q <= ST_ZERO;
          end else begin
            state_q <= ST_SCAN_CHK;
          end
        end
        ST_SCAN_CHK: begin
          if (hit) begin
            pidx_q  <= {word_q, hit_bit};
            state_q <= ST_ALLOC_VP;
          end else if (rem_wide <= VW'(WW)) begin
            st_q    <= pame_pkg::STATUS_NO_FREE;
            state_q <= ST_ZERO;
          end else begin
            rem_q   <= rem_q - CNT_W'(WW);
            word_q  <= word_q + AW'(1);
            state_q <= ST_SCAN_RD;
          end
        end
        ST_ALLOC_VP: begin
          vp_q    <= pool_base_q + VW'(pidx_q);
          state_q <= ST_ALLOC_OUT;
        end
        ST_ALLOC_OUT: begin
          if (out_free) begin
            rsp_status_q <= pame_pkg::STATUS_OK;
            rsp_page_q   <= {vp_q, pame_pkg::OFS_W'(0)};
            rsp_wr_q     <= 1'b1;
            rsp_vp_q     <= vp_q;
            rsp_value_q  <= {vp_q - kofs_q,
                             pame_pkg::PTE_WRITABLE | pame_pkg::PTE_PRESENT};
            rsp_dirp_q   <= 1'b1;
            rsp_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_FREE_CHK: begin
          if (idx_q >= VW'(cnt_eff)) begin
            st_q    <= pame_pkg::STATUS_OUTSIDE;
            state_q <= ST_ZERO;
          end else begin
            state_q <= ST_FREE_RD;
          end
        end
        ST_FREE_RD: state_q <= ST_FREE_WR;
        ST_FREE_WR: state_q <= ST_FREE_OUT;
        ST_FREE_OUT: begin
          if (out_free) begin
            rsp_status_q <= pame_pkg::STATUS_OK;
            rsp_page_q   <= '0;
            rsp_wr_q     <= 1'b1;
            rsp_vp_q     <= vp_q;
            rsp_value_q  <= '0;
            rsp_dirp_q   <= 1'b0;
            rsp_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_RUN: begin
          if (out_free) begin
            rsp_status_q <= pame_pkg::STATUS_OK;
            rsp_page_q   <= '0;
            rsp_wr_q     <= 1'b1;
            rsp_vp_q     <= vp_q;
            rsp_value_q  <= is_map_q ? {pp_q, flags_q | pame_pkg::PTE_PRESENT} : '0;
            rsp_dirp_q   <= is_map_q;
            rsp_last_q   <= (run_left_q == RUN_W'(1));
            vp_q         <= vp_q + VW'(1);
            pp_q         <= pp_q + VW'(1);
            run_left_q   <= run_left_q - RUN_W'(1);
            if (run_left_q == RUN_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_ZERO: begin
          if (out_free) begin
            rsp_status_q <= st_q;
            rsp_page_q   <= '0;
            rsp_wr_q     <= 1'b0;
            rsp_vp_q     <= '0;
            rsp_value_q  <= '0;
            rsp_dirp_q   <= 1'b0;
            rsp_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.page_address = rsp_page_q;
  assign rsp_o.entry_write  = rsp_wr_q;
  assign rsp_o.dir_index    = rsp_vp_q[VW-1:pame_pkg::IDX_W];
  assign rsp_o.table_index  = rsp_vp_q[pame_pkg::IDX_W-1:0];
  assign rsp_o.entry_value  = rsp_value_q;
  assign rsp_o.dir_present  = rsp_dirp_q;
  assign rsp_o.last         = rsp_last_q;

  `PAME_ASSERT(a_no_rw_same_cycle, !(ram_we && ram_re), "map RAM read and write in one cycle")
  `PAME_ASSERT_IMPLY(a_run_nonzero, state_q == ST_RUN, run_left_q != '0, "run entered with no pages left")
  `PAME_ASSERT_IMPLY(a_err_is_last, rsp_valid_q && (rsp_status_q != pame_pkg::STATUS_OK), rsp_last_q && !rsp_wr_q, "error beat not final or carries a PTE write")
  `PAME_ASSERT_IMPLY(a_nowrite_zero, rsp_valid_q && !rsp_wr_q, (rsp_vp_q == '0) && (rsp_value_q == '0) && !rsp_dirp_q, "beat without PTE write has nonzero entry fields")

endmodule

FILE: rtl/pame_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pame_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
